// File: src/oale_pkg.sv
// Shared types and constants for the ordered array list engine.
// Used by oale_core and ordered_array_list_engine; no dependencies.
package oale_pkg;

    localparam int CMD_W = 3;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int CAP_W = 9;
    localparam int ST_W  = 2;

    localparam int CAP_MAX        = (1 << CAP_W) - 1;
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CAP_RESET      = 256;

    typedef logic [CAP_W-1:0] t_cnt;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_SEARCH = 3'd4,
        CMD_CLEAR  = 3'd5,
        CMD_ZERO   = 3'd6,
        CMD_DEDUP  = 3'd7
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd             cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             found;
        logic [POS_W-1:0] found_pos;
        t_cnt             length;
        t_status          status;
    } t_result;

endpackage

// File: src/oale_core.sv
// Command sequencer and entry store of the ordered array list engine.
// Depends on oale_pkg for command, status and result types.
module oale_core #(
    parameter int DEPTH      = oale_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = oale_pkg::DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  oale_pkg::t_req    i_req,
    input  oale_pkg::t_cnt    i_cap,
    input  logic              i_res_free,
    output logic              o_busy,
    output logic              o_done,
    output oale_pkg::t_result o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int DW = DATA_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SHUP,
        S_SHDN,
        S_SRCH,
        S_ZERO,
        S_DD_START,
        S_DD_LOAD,
        S_DD_SCAN,
        S_DD_KEEP,
        S_FIN
    } t_state;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_q;

    t_state                     r_state, n_state;
    logic [oale_pkg::POS_W-1:0] r_pos, n_pos;
    logic [DW-1:0]              r_val, n_val;
    oale_pkg::t_cnt             r_count, n_count;
    oale_pkg::t_cnt             r_idx, n_idx;
    oale_pkg::t_cnt             r_wa, n_wa;
    oale_pkg::t_cnt             r_rdpos, n_rdpos;
    oale_pkg::t_cnt             r_j, n_j;
    oale_pkg::t_cnt             r_w, n_w;
    logic                       r_pend, n_pend;
    logic                       r_chk, n_chk;
    logic [DW-1:0]              r_x, n_x;
    logic [DW-1:0]              r_rd, n_rd;
    logic                       r_fnd, n_fnd;
    logic [oale_pkg::POS_W-1:0] r_fpos, n_fpos;
    oale_pkg::t_status          r_status, n_status;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [DW-1:0] mem_wd;
    logic [AW-1:0] mem_ra;
    oale_pkg::t_cnt req_pos;

    assign req_pos = oale_pkg::t_cnt'(i_req.pos);

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_val    = r_val;
        n_count  = r_count;
        n_idx    = r_idx;
        n_wa     = r_wa;
        n_rdpos  = r_rdpos;
        n_j      = r_j;
        n_w      = r_w;
        n_pend   = r_pend;
        n_chk    = r_chk;
        n_x      = r_x;
        n_rd     = r_rd;
        n_fnd    = r_fnd;
        n_fpos   = r_fpos;
        n_status = r_status;
        mem_we   = 1'b0;
        mem_wa   = AW'(r_wa);
        mem_wd   = r_q;
        mem_ra   = AW'(r_idx);
        o_done   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_pos    = i_req.pos;
                    n_val    = DW'(i_req.value);
                    n_rd     = '0;
                    n_fnd    = 1'b0;
                    n_fpos   = '0;
                    n_status = oale_pkg::ST_OK;
                    n_pend   = 1'b0;
                    n_chk    = 1'b0;
                    n_state  = S_FIN;
                    case (i_req.cmd)
                        oale_pkg::CMD_READ: begin
                            if (req_pos < r_count) begin
                                mem_ra  = AW'(req_pos);
                                n_state = S_READ;
                            end else begin
                                n_status = oale_pkg::ST_RANGE;
                            end
                        end
                        oale_pkg::CMD_INSERT: begin
                            if (r_count >= i_cap) begin
                                n_status = oale_pkg::ST_FULL;
                            end else if (req_pos > r_count) begin
                                n_status = oale_pkg::ST_RANGE;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_SHUP;
                            end
                        end
                        oale_pkg::CMD_DELETE: begin
                            if (req_pos < r_count) begin
                                n_idx   = req_pos;
                                n_state = S_SHDN;
                            end else begin
                                n_status = oale_pkg::ST_RANGE;
                            end
                        end
                        oale_pkg::CMD_WRITE: begin
                            if (req_pos < r_count) begin
                                mem_we = 1'b1;
                                mem_wa = AW'(req_pos);
                                mem_wd = DW'(i_req.value);
                            end else begin
                                n_status = oale_pkg::ST_RANGE;
                            end
                        end
                        oale_pkg::CMD_SEARCH: begin
                            n_idx   = '0;
                            n_state = S_SRCH;
                        end
                        oale_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        oale_pkg::CMD_ZERO: begin
                            n_idx   = '0;
                            n_state = S_ZERO;
                        end
                        oale_pkg::CMD_DEDUP: begin
                            n_idx   = '0;
                            n_w     = '0;
                            n_state = S_DD_START;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rd    = r_q;
                n_state = S_FIN;
            end
            S_SHUP: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if (r_idx > oale_pkg::t_cnt'(r_pos)) begin
                    mem_ra = AW'(r_idx - oale_pkg::t_cnt'(1));
                    n_wa   = r_idx;
                    n_idx  = r_idx - oale_pkg::t_cnt'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        mem_we  = 1'b1;
                        mem_wa  = AW'(oale_pkg::t_cnt'(r_pos));
                        mem_wd  = r_val;
                        n_count = r_count + oale_pkg::t_cnt'(1);
                        n_state = S_FIN;
                    end
                end
            end
            S_SHDN: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if (r_idx + oale_pkg::t_cnt'(1) < r_count) begin
                    mem_ra = AW'(r_idx + oale_pkg::t_cnt'(1));
                    n_wa   = r_idx;
                    n_idx  = r_idx + oale_pkg::t_cnt'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - oale_pkg::t_cnt'(1);
                        n_state = S_FIN;
                    end
                end
            end
            S_SRCH: begin
                if (r_chk && (r_q == r_val)) begin
                    n_fnd  = 1'b1;
                    n_fpos = r_rdpos[oale_pkg::POS_W-1:0];
                end
                if (r_idx < r_count) begin
                    mem_ra  = AW'(r_idx);
                    n_rdpos = r_idx;
                    n_idx   = r_idx + oale_pkg::t_cnt'(1);
                    n_chk   = 1'b1;
                end else begin
                    n_chk = 1'b0;
                    if (!r_chk) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_ZERO: begin
                if (r_idx < r_count) begin
                    mem_we = 1'b1;
                    mem_wa = AW'(r_idx);
                    mem_wd = '0;
                    n_idx  = r_idx + oale_pkg::t_cnt'(1);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DD_START: begin
                if (r_idx >= r_count) begin
                    n_count = r_w;
                    n_state = S_FIN;
                end else begin
                    mem_ra  = AW'(r_idx);
                    n_state = S_DD_LOAD;
                end
            end
            S_DD_LOAD: begin
                n_x = r_q;
                if (r_w == '0) begin
                    n_state = S_DD_KEEP;
                end else begin
                    mem_ra  = '0;
                    n_j     = oale_pkg::t_cnt'(1);
                    n_state = S_DD_SCAN;
                end
            end
            S_DD_SCAN: begin
                if (r_q == r_x) begin
                    n_idx   = r_idx + oale_pkg::t_cnt'(1);
                    n_state = S_DD_START;
                end else if (r_j == r_w) begin
                    n_state = S_DD_KEEP;
                end else begin
                    mem_ra = AW'(r_j);
                    n_j    = r_j + oale_pkg::t_cnt'(1);
                end
            end
            S_DD_KEEP: begin
                mem_we  = 1'b1;
                mem_wa  = AW'(r_w);
                mem_wd  = r_x;
                n_w     = r_w + oale_pkg::t_cnt'(1);
                n_idx   = r_idx + oale_pkg::t_cnt'(1);
                n_state = S_DD_START;
            end
            S_FIN: begin
                if (i_res_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_q <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_chk   <= n_chk;
        end
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_wa     <= n_wa;
        r_rdpos  <= n_rdpos;
        r_j      <= n_j;
        r_w      <= n_w;
        r_x      <= n_x;
        r_rd     <= n_rd;
        r_fnd    <= n_fnd;
        r_fpos   <= n_fpos;
        r_status <= n_status;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_res.read_value = oale_pkg::VAL_W'(r_rd);
    assign o_res.found      = r_fnd;
    assign o_res.found_pos  = r_fpos;
    assign o_res.length     = r_count;
    assign o_res.status     = r_status;

endmodule

// File: src/ordered_array_list_engine.sv
// Top level of the ordered array list engine: capacity register and result register.
// Depends on oale_pkg and oale_core.
//
//   channel  direction  handshake                    words
//   command  in         i_in_valid / o_in_stall      i_cmd, i_pos, i_value
//   result   out        o_out_valid / i_out_stall    o_read_value .. o_status
//   config   in         i_cfg_we                     i_cfg_data (capacity)
//
// Insert and delete shift the entries from pos upward one at a time, search and zero
// step through every entry, and duplicate removal compares each entry with those kept
// so far, all through the single read and single write port of the entry store.
// Reset is synchronous: length 0, capacity 256, no clearing pass over the store.
// A new command is taken while the previous result waits in the output register;
// the sequencer then holds its result until that register frees.
module ordered_array_list_engine #(
    parameter int DEPTH      = oale_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = oale_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [oale_pkg::CMD_W-1:0]        i_cmd,
    input  logic [oale_pkg::POS_W-1:0]        i_pos,
    input  logic signed [oale_pkg::VAL_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [oale_pkg::VAL_W-1:0] o_read_value,
    output logic                              o_found,
    output logic [oale_pkg::POS_W-1:0]        o_found_pos,
    output logic [oale_pkg::CAP_W-1:0]        o_length,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    output logic [oale_pkg::ST_W-1:0]         o_status,
    input  logic                              i_cfg_we,
    input  logic [oale_pkg::CAP_W-1:0]        i_cfg_data
);

    localparam oale_pkg::t_cnt DEPTH_LIM = (DEPTH > oale_pkg::CAP_MAX) ?
        oale_pkg::t_cnt'(oale_pkg::CAP_MAX) : oale_pkg::t_cnt'(DEPTH);

    oale_pkg::t_cnt    r_cap;
    oale_pkg::t_cnt    cap_use;
    logic              r_out_vld;
    oale_pkg::t_result r_out;
    logic              r_out_empty;
    logic              r_out_full;

    logic              accept;
    logic              res_free;
    logic              core_busy;
    logic              core_done;
    oale_pkg::t_req    req;
    oale_pkg::t_result core_res;

    assign cap_use    = (r_cap > DEPTH_LIM) ? DEPTH_LIM : r_cap;
    assign o_in_stall = core_busy;
    assign accept     = i_in_valid && !core_busy;
    assign res_free   = !r_out_vld || !i_out_stall;

    assign req.cmd   = oale_pkg::t_cmd'(i_cmd);
    assign req.pos   = i_pos;
    assign req.value = $unsigned(i_value);

    oale_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_req      (req),
        .i_cap      (cap_use),
        .i_res_free (res_free),
        .o_busy     (core_busy),
        .o_done     (core_done),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= oale_pkg::t_cnt'(oale_pkg::CAP_RESET);
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (core_done) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
        if (core_done) begin
            r_out       <= core_res;
            r_out_empty <= (core_res.length == '0);
            r_out_full  <= (core_res.length >= cap_use);
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_read_value = $signed(r_out.read_value);
    assign o_found      = r_out.found;
    assign o_found_pos  = r_out.found_pos;
    assign o_length     = r_out.length;
    assign o_is_empty   = r_out_empty;
    assign o_is_full    = r_out_full;
    assign o_status     = r_out.status;

    a_done_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_done |-> res_free)
        else $error("result produced while output register occupied");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> core_busy)
        else $error("sequencer not busy after taking a command");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_length <= DEPTH_LIM))
        else $error("length beyond store depth");

    a_full_unchanged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_done && (core_res.status == oale_pkg::ST_FULL)) |-> (core_res.length >= cap_use))
        else $error("insert refused while list not full");

endmodule
